[rtl/assert_macros.svh]
// Assertion macros for the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Antecedent at one edge implies consequent at the next edge.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: expected follow-up did not occur");

`endif

[rtl/swm_pkg.sv]
// Shared constants and types for the sliding window median core.
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int AGE_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W      = 7;

    // Data handed from one cell to its neighbors every cycle.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [AGE_W-1:0]         age;
        logic                     mv_left;
        logic                     mv_right;
    } cell_link_t;

endpackage

[rtl/swm_sample_if.sv]
// Valid/ready channel carrying one input sample per transfer.
interface swm_sample_if import swm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[rtl/swm_median_if.sv]
// Valid/ready channel carrying one median result per transfer.
interface swm_median_if import swm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

[rtl/swm_cell.sv]
// One sorted-window cell: holds a value and its age, exchanges with neighbors.
module swm_cell import swm_pkg::*;
(
    input  logic                     clk,
    input  logic                     shift_en,
    input  logic signed [DATA_W-1:0] sample,
    input  logic [CNT_W-1:0]         win_len,
    input  logic                     valid,
    input  logic                     drop_in,
    input  cell_link_t               left,
    input  cell_link_t               right,
    output logic                     drop_out,
    output cell_link_t               link
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [AGE_W-1:0]         age_reg;
    logic [AGE_W-1:0]         age_next;
    logic                     drop;
    logic                     gt;
    logic                     stay;

    always_comb
    begin
        // oldest entry leaves the window
        drop = valid && ((CNT_W'(age_reg) + CNT_W'(1)) >= win_len);
        gt   = valid && (value_reg > sample);
        // entry keeps its slot when removal below and insertion below cancel
        stay = valid && !drop && (drop_in == gt);

        link.value    = value_reg;
        link.age      = age_reg;
        link.mv_left  = valid && !drop && drop_in && !gt;
        link.mv_right = valid && !drop && !drop_in && gt;
        drop_out      = drop_in || drop;

        if (right.mv_left)
        begin
            value_next = right.value;
            age_next   = right.age + AGE_W'(1);
        end
        else if (left.mv_right)
        begin
            value_next = left.value;
            age_next   = left.age + AGE_W'(1);
        end
        else if (stay)
        begin
            value_next = value_reg;
            age_next   = age_reg + AGE_W'(1);
        end
        else
        begin
            value_next = sample;
            age_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

[rtl/swm_median_pick.sv]
// Registered one-hot selection of the median cell, first level in groups of eight.
module swm_median_pick import swm_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] cell_value [MAX_WINDOW],
    input  logic [MAX_WINDOW-1:0]    sel,
    output logic signed [DATA_W-1:0] picked
);

    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [DATA_W-1:0] grp_reg  [GROUPS];
    logic [DATA_W-1:0] grp_next [GROUPS];
    logic [DATA_W-1:0] acc;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if ((g * GROUP_SIZE + k) < MAX_WINDOW)
                begin
                    grp_next[g] = grp_next[g]
                        | (cell_value[g * GROUP_SIZE + k]
                           & {DATA_W{sel[g * GROUP_SIZE + k]}});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_next;
        end
    end

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            acc = acc | grp_reg[g];
        end
        picked = signed'(acc);
    end

endmodule

[rtl/sliding_window_median_core.sv]
// Top level of the sliding window running median filter.
//
// Usage:
//   sample_ch (sink): one signed 32-bit sample per transfer.
//   median_ch (source): lower median of the last window_len samples, one
//     result per sample once window_len samples have arrived since reset or
//     since the last configuration write; earlier samples give no result.
//   cfg_we/cfg_wdata: writes window_len (0 is taken as 1, above 64 as 64)
//     and restarts the fill phase. Write only while the core is idle.
// Timing:
//   A sample is inserted into a row of 64 sorted cells in the cycle it is
//   accepted; every cell updates in parallel with its neighbors, so one
//   sample per clock is sustained while median_ch keeps up. The median
//   reaches median_ch through cells -> group select -> output reg.
// Reset: window_len = 1, window empty, no result pending.
// Stall: while median_ch is held off, results back up into the pick and
//   cell stages; sample_ch.ready drops once the cell stage holds an
//   unpicked result. No result is lost or repeated.
module sliding_window_median_core import swm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    swm_sample_if.sink         sample_ch,
    swm_median_if.source       median_ch,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    `include "assert_macros.svh"

    // configuration
    logic [CNT_W-1:0]      win_len_reg;
    logic [CNT_W-1:0]      win_len_next;
    logic [CNT_W-1:0]      mid_idx;
    logic [MAX_WINDOW-1:0] mid_sel_reg;
    logic [MAX_WINDOW-1:0] mid_sel_next;

    // window occupancy
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [CNT_W-1:0]      fill_new;

    // pipeline control
    logic                  pend_reg;
    logic                  pend_next;
    logic                  grp_valid_reg;
    logic                  grp_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic signed [DATA_W-1:0] median_reg;
    logic signed [DATA_W-1:0] picked;

    logic                  in_xfer;
    logic                  grp_load;
    logic                  out_load;
    logic                  has_result;

    // cell row
    cell_link_t               link       [MAX_WINDOW];
    logic                     drop_chain [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0]    cell_valid;
    logic signed [DATA_W-1:0] cell_value [MAX_WINDOW];

    assign drop_chain[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            cell_link_t left_link;
            cell_link_t right_link;

            assign cell_valid[i] = (CNT_W'(i) < fill_reg);
            assign cell_value[i] = link[i].value;

            if (i == 0)
            begin : g_first
                assign left_link = '0;
            end
            else
            begin : g_mid_l
                assign left_link = link[i-1];
            end

            if (i == MAX_WINDOW - 1)
            begin : g_last
                assign right_link = '0;
            end
            else
            begin : g_mid_r
                assign right_link = link[i+1];
            end

            swm_cell u_cell
            (
                .clk      (clk),
                .shift_en (in_xfer),
                .sample   (sample_ch.sample),
                .win_len  (win_len_reg),
                .valid    (cell_valid[i]),
                .drop_in  (drop_chain[i]),
                .left     (left_link),
                .right    (right_link),
                .drop_out (drop_chain[i+1]),
                .link     (link[i])
            );
        end
    endgenerate

    swm_median_pick u_pick
    (
        .clk        (clk),
        .load       (grp_load),
        .cell_value (cell_value),
        .sel        (mid_sel_reg),
        .picked     (picked)
    );

    // Handshake and stage advance. Cells hold a result until the pick
    // stage captures it; a new sample may enter in that same cycle.
    always_comb
    begin
        out_load        = grp_valid_reg && (!out_valid_reg || median_ch.ready);
        grp_load        = pend_reg && (!grp_valid_reg || out_load);
        sample_ch.ready = !pend_reg || grp_load;
        in_xfer         = sample_ch.valid && sample_ch.ready;

        // at most one entry (the oldest) leaves per sample
        fill_new   = fill_reg - CNT_W'(drop_chain[MAX_WINDOW]) + CNT_W'(1);
        has_result = (fill_new >= win_len_reg);

        pend_next      = (pend_reg && !grp_load) || (in_xfer && has_result);
        grp_valid_next = (grp_valid_reg && !out_load) || grp_load;
        out_valid_next = (out_valid_reg && !median_ch.ready) || out_load;

        // window length clamp and median rank
        if (cfg_wdata == '0)
        begin
            win_len_next = CNT_W'(1);
        end
        else if (CNT_W'(cfg_wdata) > CNT_W'(MAX_WINDOW))
        begin
            win_len_next = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_len_next = CNT_W'(cfg_wdata);
        end
        mid_idx = (win_len_next - CNT_W'(1)) >> 1;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            mid_sel_next[k] = (CNT_W'(k) == mid_idx);
        end

        if (cfg_we)
        begin
            fill_next = '0;
        end
        else if (in_xfer)
        begin
            fill_next = fill_new;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= CNT_W'(1);
            mid_sel_reg   <= MAX_WINDOW'(1);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            grp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_len_reg <= win_len_next;
                mid_sel_reg <= mid_sel_next;
            end
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            grp_valid_reg <= grp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg <= picked;
        end
    end

    assign median_ch.valid  = out_valid_reg;
    assign median_ch.median = median_reg;

    `SWM_ASSERT_ALWAYS(a_fill_le_window, fill_reg <= win_len_reg)
    `SWM_ASSERT_ALWAYS(a_mid_sel_onehot, $onehot(mid_sel_reg))
    `SWM_ASSERT_NEXT(a_result_pends, in_xfer && has_result && !cfg_we, pend_reg)
    `SWM_ASSERT_NEXT(a_pick_to_out, out_load, out_valid_reg)

endmodule

[test/tb.sv]
// Self-checking bench for sliding_window_median_core: predicted lower medians vs. output transfers.
module tb import swm_pkg::*;;

    typedef logic signed [DATA_W-1:0] sample_t;

    localparam int HOLD_CYCLES   = 300;   // long output hold-off, in clocks
    localparam int SETTLE_CYCLES = 4;     // pick and output stages, give them margin
    localparam int TAIL_CYCLES   = 8;     // quiet time after the last median
    localparam int STUCK_LIMIT   = 3000;  // clocks without any transfer
    localparam int PRINT_CAP     = 40;    // mismatch lines shown before going quiet

    // Tracks the window contents the way the cells do: entries kept in
    // ascending order, each tagged with its age (0 = newest). Every accepted
    // sample ages the window, drops what falls out, and inserts the new value
    // after any equal ones. Once full, the lower median is due.
    class median_tracker;
        sample_t     win_val [MAX_WINDOW];
        int unsigned win_age [MAX_WINDOW];
        int unsigned fill;
        int unsigned wlen;
        sample_t     medians_due [$];
        int unsigned mismatches;
        int unsigned compared;

        function new();
            fill       = 0;
            wlen       = 1;
            mismatches = 0;
            compared   = 0;
        endfunction

        // Register write: clamp to 1..MAX_WINDOW and flush the window.
        function void set_window_len(logic [CFG_W-1:0] v);
            if (v == 0)
                wlen = 1;
            else if (v > MAX_WINDOW)
                wlen = MAX_WINDOW;
            else
                wlen = v;
            fill = 0;
        endfunction

        function void note_sample(sample_t s);
            int unsigned kept;
            int unsigned pos;
            kept = 0;
            // age survivors, drop the one leaving the window
            for (int unsigned i = 0; i < fill; i++)
            begin
                if (win_age[i] + 1 < wlen)
                begin
                    win_val[kept] = win_val[i];
                    win_age[kept] = win_age[i] + 1;
                    kept++;
                end
            end
            // insert after every entry <= s
            pos = kept;
            while (pos > 0 && win_val[pos-1] > s)
            begin
                win_val[pos] = win_val[pos-1];
                win_age[pos] = win_age[pos-1];
                pos--;
            end
            win_val[pos] = s;
            win_age[pos] = 0;
            fill = kept + 1;
            if (fill >= wlen)
                medians_due.push_back(win_val[(wlen + 1) / 2 - 1]);
        endfunction

        function int unsigned pending();
            return medians_due.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_median(sample_t got);
            sample_t want;
            if (medians_due.size() == 0)
            begin
                report($sformatf("median %0d arrived with none outstanding", got));
                return;
            end
            want = medians_due.pop_front();
            compared++;
            if (got !== want)
                report($sformatf("median: got %0d, predicted %0d", got, want));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    swm_sample_if sample_ch ();
    swm_median_if median_ch ();

    sliding_window_median_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .median_ch (median_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    median_tracker sb = new();

    // Bench-wide knobs shared by the driver processes.
    logic        calm;          // no idling on either side while set
    logic        hold_off_req;  // ask the median side for a long hold-off
    int unsigned samples_sent;
    int unsigned settings_used;
    int unsigned stuck;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Every block input and bench-driven signal is known from time zero.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        median_ch.ready  = 1'b0;
        calm             = 1'b0;
        hold_off_req     = 1'b0;
        samples_sent     = 0;
        settings_used    = 0;
        stuck            = 0;
    end

    // Handshakes are judged at the falling edge, where everything driven at
    // the rising edge has settled; a valid&&ready seen here is the transfer
    // that completes at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (median_ch.valid === 1'b1 && median_ch.ready === 1'b1)
                sb.check_median(median_ch.median);

            // Watchdog: count clocks with no transfer on either channel.
            if ((sample_ch.valid && sample_ch.ready) || (median_ch.valid && median_ch.ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d medians outstanding",
                         stuck, sb.pending());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Median side: ready dropped about a third of the time, always high in a
    // calm stretch, and held low for HOLD_CYCLES when asked. The hold-off is
    // timed here so the sample side keeps offering meanwhile and the core
    // has to back up and drop sample_ch.ready.
    initial
    begin : median_sink
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                median_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                median_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // Offer one sample, hold it until the core takes it, then maybe idle.
    // Called right after a rising edge; returns on one with no pending
    // assignment to valid in that step.
    task automatic offer_sample(input sample_t s);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(negedge clk);
        while (!sample_ch.ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_sample(s);
        samples_sent++;
        // geometric gap: roughly a third of the clocks go idle
        if (!calm)
            while ($urandom_range(0, 99) < 33)
            begin
                sample_ch.valid <= 1'b0;
                @(posedge clk);
            end
    endtask

    // Stop offering and wait for every predicted median to come back.
    task automatic drain_medians();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Register write with the core idle: drained, then a few settle clocks
    // since a sample in the fill phase leaves nothing to wait on.
    task automatic write_window_len(input logic [CFG_W-1:0] v);
        drain_medians();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_window_len(v);
        settings_used++;
    endtask

    // Mix of full-range values, a narrow band around zero (lots of ties),
    // and values hugging both ends of the signed range.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return sample_t'($urandom);
        else if (pick < 7)
            return sample_t'(int'($urandom_range(0, 16)) - 8);
        else if (pick == 7)
            return sample_t'(32'h8000_0000 + $urandom_range(0, 3));
        else if (pick == 8)
            return sample_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
        else
            return sample_t'(int'($urandom_range(0, 1)) - 1);
    endfunction

    initial
    begin : stimulus
        // Random phases: window setting and number of samples. The list
        // visits both ends, plus writes of 65 and 127 that must clamp.
        logic [CFG_W-1:0] phase_len [9];
        int               phase_items [9];
        phase_len   = '{7'd4, 7'd5, 7'd127, 7'd1, 7'd2, 7'd16, 7'd33, 7'd65, 7'd7};
        phase_items = '{150, 200, 220, 100, 100, 150, 120, 140, 120};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Window of one straight out of reset: each median is the sample.
        offer_sample(32'sh8000_0000);
        offer_sample(32'sh7FFF_FFFF);
        offer_sample('0);
        offer_sample('1);

        // A write of zero clamps to a window of one.
        write_window_len(7'd0);
        offer_sample(32'sh5555_5555);
        offer_sample(32'shAAAA_AAAA);

        // Window of three: ties, then both extremes pushing through eviction.
        write_window_len(7'd3);
        offer_sample(32'sd5);
        offer_sample(32'sd5);
        offer_sample(32'sd5);
        offer_sample(-32'sd7);
        offer_sample(32'sh7FFF_FFFF);
        offer_sample(32'sh8000_0000);
        offer_sample(32'sd5);
        offer_sample('0);

        // Even window: lower of the two middle values.
        write_window_len(7'd2);
        offer_sample(32'sd10);
        offer_sample(32'sd3);
        offer_sample(-32'sd4);
        offer_sample(32'sh8000_0000);

        // Random part.
        for (int p = 0; p < 9; p++)
        begin
            write_window_len(phase_len[p]);
            calm = (p == 0);            // one stretch with no idling at all
            if (p == 1)
                hold_off_req = 1'b1;    // core fills up and stalls its input
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // mid-phase pause with the window full: sample side waits
                // until every outstanding median has been taken
                if (p == 5 && n == phase_items[p] / 2)
                    drain_medians();
                offer_sample(random_sample());
            end
        end
        calm = 1'b0;

        drain_medians();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d samples over %0d register writes, %0d medians compared",
                 samples_sent, settings_used, sb.compared);
        $display("windows 1..64 incl. clamped writes, ties, range ends, hold-off and drain");
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
